/* sv/frs_pkg.sv */
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types, constants and register map of the relaxation step block.
// ----------------------------------------------------------------------------
package frs_pkg;

   // vector geometry
   localparam int N_COMP         = 5;
   localparam int DEF_COMPONENTS = 5;
   localparam int DEF_MAX_ITEMS  = 1048576;

   // fixed-point constants
   localparam logic [31:0] DT_RESET     = 32'd167772;
   localparam logic [25:0] ONE_Q24      = 26'd16777216;
   localparam logic [24:0] ALPHA_MAX    = 25'h1FF_FFFF;
   localparam int          RESET_PERIOD = 500;
   localparam int          DIV_STEPS    = 96;

   // register defaults
   localparam logic [24:0] DEF_ALPHA_START = 25'd16609444;
   localparam logic [24:0] DEF_ALPHA_DECAY = 25'd15099494;
   localparam logic [24:0] DEF_ALPHA_FLOOR = 25'd0;
   localparam logic [31:0] DEF_STEP_GROW   = 32'd17616077;
   localparam logic [24:0] DEF_STEP_SHRINK = 25'd15938355;
   localparam logic [31:0] DEF_STEP_CEIL   = 32'd1677722;
   localparam logic [31:0] DEF_STEP_FLOOR  = 32'd0;
   localparam logic [15:0] DEF_MIN_POS     = 16'd5;

   // register indexes
   localparam logic [2:0] REG_ALPHA_START = 3'd0;
   localparam logic [2:0] REG_ALPHA_DECAY = 3'd1;
   localparam logic [2:0] REG_ALPHA_FLOOR = 3'd2;
   localparam logic [2:0] REG_STEP_GROW   = 3'd3;
   localparam logic [2:0] REG_STEP_SHRINK = 3'd4;
   localparam logic [2:0] REG_STEP_CEIL   = 3'd5;
   localparam logic [2:0] REG_STEP_FLOOR  = 3'd6;
   localparam logic [2:0] REG_MIN_POS     = 3'd7;

   // item and result kinds
   localparam logic ACT_REDUCE   = 1'b0;
   localparam logic ACT_MIX      = 1'b1;
   localparam logic KIND_VEL     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISP, ST_RED, ST_RED_WAIT, ST_SQRT_F, ST_DIV_PEAK,
      ST_DIV_SCALE, ST_SQRT_S, ST_GAIN, ST_PROD, ST_APPLY, ST_MIX,
      ST_MIX_WAIT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {MUL_RED, MUL_MIX, MUL_GAIN, MUL_UPD} mul_op_type;
   typedef enum logic {SQ_FNORM, SQ_QUOT} sqrt_sel_type;
   typedef enum logic {DV_PEAK, DV_SCALE} div_sel_type;

   typedef struct packed {
      logic [24:0] alpha_start;
      logic [24:0] alpha_decay;
      logic [24:0] alpha_floor;
      logic [31:0] step_grow;
      logic [24:0] step_shrink;
      logic [31:0] step_ceiling;
      logic [31:0] step_floor;
      logic [15:0] min_positive_steps;
   } cfg_type;

   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_op_type   mul_op;
      logic         issue;
      logic [2:0]   comp;
      logic         sqrt_start;
      sqrt_sel_type sqrt_sel;
      logic         div_start;
      div_sel_type  div_sel;
      logic         peak_load;
      logic         scale_load;
      logic         gain_load;
      logic         apply;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic last;
      logic pipe_busy;
      logic sqrt_busy;
      logic sqrt_done;
      logic div_busy;
      logic div_done;
      logic fnorm_zero;
      logic out_free;
   } status_type;

endpackage

/* sv/frs_isqrt.sv */
// ----------------------------------------------------------------------------
// frs_isqrt
// Floored square root of a 64-bit value, computed iteratively; busy until done.
// ----------------------------------------------------------------------------
module frs_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   output logic        busy,
   output logic        done,
   output logic [31:0] result
);
   localparam logic [63:0] TOP_BIT = 64'h4000_0000_0000_0000;

   logic        busy_ff;
   logic        done_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial_in;
   logic        take_in;

   // one restoring step
   always_comb begin
      trial_in = res_ff + bit_ff;
      take_in  = (x_ff >= trial_in);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         res_ff <= '0;
         bit_ff <= TOP_BIT;
      end else if (busy_ff) begin
         if (take_in) begin
            x_ff   <= x_ff - trial_in;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff[31:0];
endmodule

/* sv/frs_div.sv */
// ----------------------------------------------------------------------------
// frs_div
// Bit-serial floor(num * 2^32 / den), saturated to 64 bits, one bit a cycle.
// ----------------------------------------------------------------------------
module frs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic        done,
   output logic [63:0] quot
);
   import frs_pkg::*;

   localparam int SW = $clog2(DIV_STEPS);

   logic          busy_ff;
   logic          done_ff;
   logic [SW-1:0] cnt_ff;
   logic [95:0]   sh_ff;
   logic [63:0]   den_ff;
   logic [63:0]   r_ff;
   logic [63:0]   q_ff;
   logic          ovf_ff;
   logic [63:0]   r_sh_in;
   logic          take_in;
   logic [63:0]   r_in;

   // one shift-subtract step, the carry out of the remainder forces a take
   always_comb begin
      r_sh_in = {r_ff[62:0], sh_ff[95]};
      take_in = r_ff[63] || (r_sh_in >= den_ff);
      r_in    = take_in ? (r_sh_in - den_ff) : r_sh_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == SW'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= {num, 32'd0};
         den_ff <= den;
         r_ff   <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         sh_ff  <= {sh_ff[94:0], 1'b0};
         r_ff   <= r_in;
         q_ff   <= {q_ff[62:0], take_in};
         ovf_ff <= ovf_ff | q_ff[63];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = ovf_ff ? '1 : q_ff;
endmodule

/* sv/frs_dp.sv */
// ----------------------------------------------------------------------------
// frs_dp
// Datapath: operand capture, shared multiplier bank, norm accumulators,
// velocity mix pipeline, step update and the result register.
// ----------------------------------------------------------------------------
module frs_dp #(
   parameter int MAX_ITEMS  = frs_pkg::DEF_MAX_ITEMS,
   parameter int COMPONENTS = frs_pkg::DEF_COMPONENTS
) (
   input  logic                clock,
   input  logic                reset,
   input  frs_pkg::cmd_type    cmd,
   output frs_pkg::status_type status,
   input  frs_pkg::cfg_type    cfg,
   input  logic [319:0]        req_tdata,
   input  logic                req_tlast,
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [255:0]        rsp_tdata,
   output logic                rsp_tuser
);
   import frs_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);

   // captured item
   logic               action_ff;
   logic               last_ff;
   logic signed [31:0] f_ff [N_COMP];
   logic signed [31:0] v_ff [N_COMP];

   // step state
   logic [63:0]        fnorm_ff;
   logic [63:0]        vnorm_ff;
   logic signed [63:0] power_ff;
   logic [CW-1:0]      count_ff;
   logic [31:0]        scale_ff;
   logic [40:0]        gain_ff;
   logic [24:0]        mix_alpha_ff;
   logic [24:0]        alpha_ff;
   logic [31:0]        dt_ff;
   logic [31:0]        run_ff;
   logic [31:0]        step_ff;
   logic [8:0]         mod_ff;
   logic               zero_vel_ff;
   logic [31:0]        peak_ff;

   // multiplier bank
   logic signed [32:0] ma0, mb0, ma1, mb1, ma2, mb2;
   logic signed [65:0] p0_ff, p1_ff, p2_ff;
   logic signed [31:0] sel_f, sel_v;
   logic [31:0]        mag;
   logic signed [25:0] one_minus;

   // pipeline stages
   logic               s1_valid_ff, s1_mix_ff, s1_neg_ff;
   logic [2:0]         s1_comp_ff;
   logic               s2_valid_ff, s2_neg_ff;
   logic [2:0]         s2_comp_ff;
   logic signed [63:0] t1_ff;
   logic [62:0]        t2m_ff;
   logic [31:0]        nv_ff [N_COMP];

   // result register
   logic               rsp_valid_ff;
   logic [255:0]       rsp_data_ff;
   logic               rsp_user_ff;

   // iterative units
   logic [63:0] sqrt_x, div_num, div_den, div_q;
   logic [31:0] sqrt_res;
   logic        sqrt_busy, sqrt_done, div_busy, div_done;

   frs_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.sqrt_start),
      .x      (sqrt_x),
      .busy   (sqrt_busy),
      .done   (sqrt_done),
      .result (sqrt_res)
   );

   frs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   // unit operand select
   always_comb begin
      unique case (cmd.sqrt_sel)
         SQ_FNORM: sqrt_x = fnorm_ff;
         SQ_QUOT:  sqrt_x = div_q;
      endcase
      unique case (cmd.div_sel)
         DV_PEAK: begin
            div_num = {32'd0, sqrt_res};
            div_den = {{(64 - CW){1'b0}}, count_ff};
         end
         DV_SCALE: begin
            div_num = vnorm_ff;
            div_den = fnorm_ff;
         end
      endcase
   end

   // item capture, unused components read as zero
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_tuser;
         last_ff   <= req_tlast;
         for (int j = 0; j < N_COMP; j++) begin
            f_ff[j] <= (j < COMPONENTS) ? req_tdata[32*j +: 32] : '0;
            v_ff[j] <= (j < COMPONENTS) ? req_tdata[160 + 32*j +: 32] : '0;
         end
      end
   end

   // multiplier operand select
   always_comb begin
      sel_f     = f_ff[cmd.comp];
      sel_v     = v_ff[cmd.comp];
      mag       = sel_f[31] ? (~sel_f + 32'd1) : sel_f;
      one_minus = $signed(ONE_Q24) - $signed({1'b0, mix_alpha_ff});
      unique case (cmd.mul_op)
         MUL_RED: begin
            ma0 = 33'(sel_f); mb0 = 33'(sel_f);
            ma1 = 33'(sel_v); mb1 = 33'(sel_v);
            ma2 = 33'(sel_f); mb2 = 33'(sel_v);
         end
         MUL_MIX: begin
            ma0 = 33'(sel_v);                     mb0 = 33'(one_minus);
            ma1 = $signed({1'b0, mag});           mb1 = $signed({9'd0, gain_ff[23:0]});
            ma2 = $signed({1'b0, mag});           mb2 = $signed({16'd0, gain_ff[40:24]});
         end
         MUL_GAIN: begin
            ma0 = $signed({8'd0, alpha_ff});      mb0 = $signed({1'b0, scale_ff});
            ma1 = '0;                             mb1 = '0;
            ma2 = '0;                             mb2 = '0;
         end
         MUL_UPD: begin
            ma0 = $signed({1'b0, dt_ff});         mb0 = $signed({1'b0, cfg.step_grow});
            ma1 = $signed({8'd0, alpha_ff});      mb1 = $signed({8'd0, cfg.alpha_decay});
            ma2 = $signed({1'b0, dt_ff});         mb2 = $signed({8'd0, cfg.step_shrink});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p0_ff <= ma0 * mb0;
         p1_ff <= ma1 * mb1;
         p2_ff <= ma2 * mb2;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff && s1_mix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_mix_ff  <= (cmd.mul_op == MUL_MIX);
         s1_comp_ff <= cmd.comp;
         s1_neg_ff  <= sel_f[31];
      end
   end

   // mix stage two: saturated force term
   logic [73:0] t2_in;
   always_comb begin
      t2_in = {10'd0, p1_ff[63:0]} + {p2_ff[49:0], 24'd0};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_mix_ff) begin
         t1_ff      <= p0_ff[63:0];
         t2m_ff     <= (t2_in > 74'h4000_0000_0000_0000) ? 63'h4000_0000_0000_0000
                                                          : t2_in[62:0];
         s2_neg_ff  <= s1_neg_ff;
         s2_comp_ff <= s1_comp_ff;
      end
   end

   // mix stage three: floor to Q16.16 and saturate
   logic signed [64:0] sum_in;
   logic signed [40:0] shr_in;
   logic [31:0]        nv_in;
   always_comb begin
      sum_in = {t1_ff[63], t1_ff} + (s2_neg_ff ? -$signed({2'b0, t2m_ff})
                                               :  $signed({2'b0, t2m_ff}));
      shr_in = sum_in[64:24];
      if (!shr_in[40] && (|shr_in[39:31])) begin
         nv_in = 32'h7FFF_FFFF;
      end else if (shr_in[40] && !(&shr_in[39:31])) begin
         nv_in = 32'h8000_0000;
      end else begin
         nv_in = shr_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         nv_ff[s2_comp_ff] <= nv_in;
      end
   end

   // saturating accumulation of one component's products
   logic [64:0]        fsum_in, vsum_in;
   logic signed [64:0] psum_in;
   logic [63:0]        fnorm_in, vnorm_in;
   logic signed [63:0] power_in;
   always_comb begin
      fsum_in  = {1'b0, fnorm_ff} + {1'b0, p0_ff[63:0]};
      vsum_in  = {1'b0, vnorm_ff} + {1'b0, p1_ff[63:0]};
      psum_in  = {power_ff[63], power_ff} + {p2_ff[63], p2_ff[63:0]};
      fnorm_in = fsum_in[64] ? '1 : fsum_in[63:0];
      vnorm_in = vsum_in[64] ? '1 : vsum_in[63:0];
      if (psum_in[64] != psum_in[63]) begin
         power_in = psum_in[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         power_in = psum_in[63:0];
      end
   end

   // end-of-step update of dt, alpha and the positive-power run
   logic [31:0] step_in;
   logic [8:0]  mod_in;
   logic        reset_now_in;
   logic [39:0] dg_raw;
   logic [31:0] dg_sat, dg_in;
   logic [25:0] ag_raw;
   logic [24:0] ag_sat, ag_in;
   logic [32:0] ds_raw;
   logic [31:0] ds_in;
   logic [31:0] dt_in, run_in;
   logic [24:0] alpha_in;
   always_comb begin
      step_in = step_ff + 32'd1;
      if (step_in == 32'd0 || mod_ff == 9'(RESET_PERIOD - 1)) begin
         mod_in = '0;
      end else begin
         mod_in = mod_ff + 9'd1;
      end
      reset_now_in = !(!power_ff[63] && (power_ff != 64'd0) && (mod_in != 9'd0));

      dg_raw = p0_ff[63:24];
      dg_sat = (|dg_raw[39:32]) ? 32'hFFFF_FFFF : dg_raw[31:0];
      dg_in  = (dg_sat > cfg.step_ceiling) ? cfg.step_ceiling : dg_sat;
      ag_raw = p1_ff[49:24];
      ag_sat = ag_raw[25] ? ALPHA_MAX : ag_raw[24:0];
      ag_in  = (ag_sat < cfg.alpha_floor) ? cfg.alpha_floor : ag_sat;
      ds_raw = p2_ff[56:24];
      ds_in  = (ds_raw < {1'b0, cfg.step_floor}) ? cfg.step_floor : ds_raw[31:0];

      dt_in    = dt_ff;
      alpha_in = alpha_ff;
      run_in   = run_ff;
      if (reset_now_in) begin
         dt_in    = ds_in;
         alpha_in = cfg.alpha_start;
         run_in   = '0;
      end else begin
         if (run_ff > {16'd0, cfg.min_positive_steps}) begin
            dt_in    = dg_in;
            alpha_in = ag_in;
         end
         if (run_ff != 32'hFFFF_FFFF) begin
            run_in = run_ff + 32'd1;
         end
      end
   end

   // step state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fnorm_ff     <= '0;
         vnorm_ff     <= '0;
         power_ff     <= '0;
         count_ff     <= '0;
         scale_ff     <= '0;
         gain_ff      <= '0;
         mix_alpha_ff <= '0;
         alpha_ff     <= '0;
         dt_ff        <= DT_RESET;
         run_ff       <= '0;
         step_ff      <= '0;
         mod_ff       <= '0;
         zero_vel_ff  <= 1'b0;
      end else begin
         if (cmd.capture && req_tuser == ACT_REDUCE && count_ff < CW'(MAX_ITEMS)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (s1_valid_ff && !s1_mix_ff) begin
            fnorm_ff <= fnorm_in;
            vnorm_ff <= vnorm_in;
            power_ff <= power_in;
         end
         if (cmd.scale_load) begin
            scale_ff <= (fnorm_ff == 64'd0) ? 32'd0 : sqrt_res;
         end
         if (cmd.gain_load) begin
            gain_ff <= p0_ff[56:16];
         end
         if (cmd.apply) begin
            mix_alpha_ff <= alpha_ff;
            alpha_ff     <= alpha_in;
            dt_ff        <= dt_in;
            run_ff       <= run_in;
            step_ff      <= step_in;
            mod_ff       <= mod_in;
            zero_vel_ff  <= reset_now_in;
            fnorm_ff     <= '0;
            vnorm_ff     <= '0;
            power_ff     <= '0;
            count_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.peak_load) begin
         peak_ff <= div_q[63:32];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_user_ff <= KIND_SUMMARY;
         rsp_data_ff <= {6'd0, reset_now_in, alpha_in, dt_in, peak_ff, 160'd0};
      end else if (cmd.out_load) begin
         rsp_user_ff <= KIND_VEL;
         rsp_data_ff <= zero_vel_ff ? '0
                        : {96'd0, nv_ff[4], nv_ff[3], nv_ff[2], nv_ff[1], nv_ff[0]};
      end
   end

   // status to the controller
   always_comb begin
      status.action     = action_ff;
      status.last       = last_ff;
      status.pipe_busy  = s1_valid_ff || s2_valid_ff;
      status.sqrt_busy  = sqrt_busy;
      status.sqrt_done  = sqrt_done;
      status.div_busy   = div_busy;
      status.div_done   = div_done;
      status.fnorm_zero = (fnorm_ff == 64'd0);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

/* sv/frs_ctrl.sv */
// ----------------------------------------------------------------------------
// frs_ctrl
// Sequencer: steps components through the multiplier bank and runs the
// square root, divide and update steps at the end of a reduce pass.
// ----------------------------------------------------------------------------
module frs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output frs_pkg::cmd_type    cmd,
   input  frs_pkg::status_type status
);
   import frs_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] comp_ff, comp_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      comp_in        = comp_ff;
      cmd            = '0;
      cmd.comp       = comp_ff;
      cmd.mul_op     = MUL_RED;
      cmd.sqrt_sel   = SQ_FNORM;
      cmd.div_sel    = DV_PEAK;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_DISP;
         end
         ST_DISP: begin
            comp_in  = '0;
            state_in = (status.action == ACT_MIX) ? ST_MIX : ST_RED;
         end
         ST_RED, ST_MIX: begin
            cmd.mul_en = 1'b1;
            cmd.issue  = 1'b1;
            cmd.mul_op = (state_ff == ST_MIX) ? MUL_MIX : MUL_RED;
            comp_in    = comp_ff + 3'd1;
            if (comp_ff == 3'(N_COMP - 1)) begin
               comp_in  = '0;
               state_in = (state_ff == ST_MIX) ? ST_MIX_WAIT : ST_RED_WAIT;
            end
         end
         ST_RED_WAIT: begin
            if (!status.pipe_busy) begin
               if (status.last) begin
                  cmd.sqrt_start = 1'b1;
                  cmd.sqrt_sel   = SQ_FNORM;
                  state_in       = ST_SQRT_F;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SQRT_F: begin
            if (status.sqrt_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DV_PEAK;
               state_in      = ST_DIV_PEAK;
            end
         end
         ST_DIV_PEAK: begin
            if (status.div_done) begin
               cmd.peak_load = 1'b1;
               if (status.fnorm_zero) begin
                  cmd.scale_load = 1'b1;
                  state_in       = ST_GAIN;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DV_SCALE;
                  state_in      = ST_DIV_SCALE;
               end
            end
         end
         ST_DIV_SCALE: begin
            cmd.div_sel = DV_SCALE;
            if (status.div_done) begin
               cmd.sqrt_start = 1'b1;
               cmd.sqrt_sel   = SQ_QUOT;
               state_in       = ST_SQRT_S;
            end
         end
         ST_SQRT_S: begin
            if (status.sqrt_done) begin
               cmd.scale_load = 1'b1;
               state_in       = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_GAIN;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_op    = MUL_UPD;
            cmd.gain_load = 1'b1;
            state_in      = ST_APPLY;
         end
         ST_APPLY: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_MIX_WAIT: begin
            if (!status.pipe_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // a result is only written into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.apply) |-> status.out_free)
      else $error("result written while output register occupied");

   // iterative units are never restarted while running
   assert property (@(posedge clock) disable iff (reset)
      (!cmd.div_start || !status.div_busy) && (!cmd.sqrt_start || !status.sqrt_busy))
      else $error("iterative unit restarted while busy");

   // an accepted item is dispatched on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DISP))
      else $error("accepted item not dispatched");

   // the step update only runs with the mix pipeline empty
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> !status.pipe_busy)
      else $error("step update during pipeline activity");
`endif
endmodule

/* sv/fire_relaxation_step.sv */
// ----------------------------------------------------------------------------
// fire_relaxation_step
// Reduce and mix items are taken one item at a time;
// the shared three-multiplier bank takes the five components one per cycle.
// The last reduce item also runs bit-serial divides and iterative square roots:
// two of each, or one of each if the force norm is zero. Synchronous reset clears
// the step state but the force peak, sets dt to 0.01 and restores the register defaults.
// ----------------------------------------------------------------------------
module fire_relaxation_step #(
   parameter int MAX_ITEMS  = frs_pkg::DEF_MAX_ITEMS,
   parameter int COMPONENTS = frs_pkg::DEF_COMPONENTS
) (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [319:0] req_tdata,  // force_a..force_e, vel_a..vel_e
   input  logic         req_tlast,  // last
   input  logic         req_tuser,  // action
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,  // new_vel_a..e, force_peak, step_size,
                                    // alpha_now, was_reset, zero fill
   output logic         rsp_tuser,  // result_kind
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import frs_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       wr_en;
   logic [2:0] reg_idx;

   // register write transfer
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_start        <= DEF_ALPHA_START;
         cfg_ff.alpha_decay        <= DEF_ALPHA_DECAY;
         cfg_ff.alpha_floor        <= DEF_ALPHA_FLOOR;
         cfg_ff.step_grow          <= DEF_STEP_GROW;
         cfg_ff.step_shrink        <= DEF_STEP_SHRINK;
         cfg_ff.step_ceiling       <= DEF_STEP_CEIL;
         cfg_ff.step_floor         <= DEF_STEP_FLOOR;
         cfg_ff.min_positive_steps <= DEF_MIN_POS;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ALPHA_START: cfg_ff.alpha_start        <= csr_pwdata[24:0];
            REG_ALPHA_DECAY: cfg_ff.alpha_decay        <= csr_pwdata[24:0];
            REG_ALPHA_FLOOR: cfg_ff.alpha_floor        <= csr_pwdata[24:0];
            REG_STEP_GROW:   cfg_ff.step_grow          <= csr_pwdata;
            REG_STEP_SHRINK: cfg_ff.step_shrink        <= csr_pwdata[24:0];
            REG_STEP_CEIL:   cfg_ff.step_ceiling       <= csr_pwdata;
            REG_STEP_FLOOR:  cfg_ff.step_floor         <= csr_pwdata;
            REG_MIN_POS:     cfg_ff.min_positive_steps <= csr_pwdata[15:0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_idx)
         REG_ALPHA_START: csr_prdata = {7'd0, cfg_ff.alpha_start};
         REG_ALPHA_DECAY: csr_prdata = {7'd0, cfg_ff.alpha_decay};
         REG_ALPHA_FLOOR: csr_prdata = {7'd0, cfg_ff.alpha_floor};
         REG_STEP_GROW:   csr_prdata = cfg_ff.step_grow;
         REG_STEP_SHRINK: csr_prdata = {7'd0, cfg_ff.step_shrink};
         REG_STEP_CEIL:   csr_prdata = cfg_ff.step_ceiling;
         REG_STEP_FLOOR:  csr_prdata = cfg_ff.step_floor;
         REG_MIN_POS:     csr_prdata = {16'd0, cfg_ff.min_positive_steps};
      endcase
   end

   assign csr_pready = 1'b1;

   frs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   frs_dp #(
      .MAX_ITEMS  (MAX_ITEMS),
      .COMPONENTS (COMPONENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

/* dv/tb_fire_relaxation_step.sv */
// ----------------------------------------------------------------------------
// tb_fire_relaxation_step
// Streams reduce and mix passes through the relaxation step block and compares
// every velocity and step summary with a fixed-point prediction of the step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fire_relaxation_step;
   import frs_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam int     SETTLE      = 400;

   // expected result: kind plus packed result word
   typedef struct {
      logic         kind;
      logic [255:0] word;
   } relax_result_type;

   // ------------------------------------------------------------------------
   // step predictor and scoreboard
   // ------------------------------------------------------------------------
   class relax_scoreboard;
      relax_result_type   pending[$];
      int                 errors;
      cfg_type            cfg;
      logic        [63:0] fnorm, vnorm;
      logic signed [63:0] power;
      logic        [20:0] count;
      logic        [31:0] mix_scale, dt, pos_run, step_no;
      logic        [24:0] mix_alpha, alpha;
      logic               zero_vel;

      function new();
         cfg       = '{DEF_ALPHA_START, DEF_ALPHA_DECAY, DEF_ALPHA_FLOOR, DEF_STEP_GROW,
                       DEF_STEP_SHRINK, DEF_STEP_CEIL, DEF_STEP_FLOOR, DEF_MIN_POS};
         fnorm     = 0; vnorm = 0; power = 0; count = 0;
         mix_scale = 0; mix_alpha = 0; alpha = 0; dt = DT_RESET;
         pos_run   = 0; step_no = 0; zero_vel = 0; errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_ALPHA_START: cfg.alpha_start = val[24:0];
            REG_ALPHA_DECAY: cfg.alpha_decay = val[24:0];
            REG_ALPHA_FLOOR: cfg.alpha_floor = val[24:0];
            REG_STEP_GROW:   cfg.step_grow = val;
            REG_STEP_SHRINK: cfg.step_shrink = val[24:0];
            REG_STEP_CEIL:   cfg.step_ceiling = val;
            REG_STEP_FLOOR:  cfg.step_floor = val;
            default:         cfg.min_positive_steps = val[15:0];
         endcase
      endfunction

      // floored square root
      function logic [31:0] root(logic [63:0] x);
         logic [31:0] r;
         logic [31:0] t;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= x) r = t;
         end
         return r;
      endfunction

      // one mixed component, floored to Q16.16 and saturated
      function logic [31:0] mix_one(longint v, longint f);
         longint       one_minus, t1, t2, sum, r;
         logic [63:0]  gain, mag;
         logic [127:0] prod;
         one_minus = 64'sd16777216 - longint'(mix_alpha);
         t1   = v * one_minus;
         gain = (64'(mix_alpha) * 64'(mix_scale)) >> 16;
         mag  = (f < 0) ? -f : f;
         prod = 128'(mag) * 128'(gain);
         if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
         t2   = longint'(prod[63:0]);
         sum  = t1 + ((f < 0) ? -t2 : t2);
         r    = sum >>> 24;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      // accepted input transfer: update state and queue any result
      function void note_item(logic action, logic last, logic [319:0] d);
         longint             f[5], v[5];
         logic        [64:0] us;
         logic signed [65:0] ss;
         logic        [127:0] quot;
         logic        [63:0] gd, ga;
         logic        [31:0] peak, scale;
         logic               reset_now;
         relax_result_type   res;
         for (int j = 0; j < 5; j++) begin
            f[j] = $signed(d[32*j +: 32]);
            v[j] = $signed(d[160 + 32*j +: 32]);
         end
         res.word = '0;
         if (action == ACT_MIX) begin
            res.kind = KIND_VEL;
            for (int j = 0; j < 5; j++)
               res.word[32*j +: 32] = zero_vel ? 32'd0 : mix_one(v[j], f[j]);
            pending.push_back(res);
            return;
         end
         // reduce: saturating accumulation
         for (int j = 0; j < 5; j++) begin
            us    = {1'b0, fnorm} + {1'b0, 64'(f[j] * f[j])};
            fnorm = us[64] ? '1 : us[63:0];
            us    = {1'b0, vnorm} + {1'b0, 64'(v[j] * v[j])};
            vnorm = us[64] ? '1 : us[63:0];
            ss    = 66'(power) + 66'(f[j] * v[j]);
            if (ss > 66'sh0_7FFF_FFFF_FFFF_FFFF) power = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (ss < -66'sh0_8000_0000_0000_0000) power = 64'sh8000_0000_0000_0000;
            else power = ss[63:0];
         end
         if (count < 21'(DEF_MAX_ITEMS)) count++;
         if (!last) return;

         // end of pass: summary
         step_no++;
         peak  = 32'(64'(root(fnorm)) / 64'(count));
         scale = 0;
         if (fnorm != 0) begin
            quot = {32'd0, vnorm, 32'd0} / {64'd0, fnorm};
            scale = root((quot > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : quot[63:0]);
         end
         mix_scale = scale;
         mix_alpha = alpha;
         reset_now = !(power > 0 && (step_no % RESET_PERIOD) != 0);
         if (!reset_now) begin
            if (pos_run > 32'(cfg.min_positive_steps)) begin
               gd = (64'(dt) * 64'(cfg.step_grow)) >> 24;
               ga = (64'(alpha) * 64'(cfg.alpha_decay)) >> 24;
               if (gd > 64'hFFFF_FFFF) gd = 64'hFFFF_FFFF;
               if (gd > 64'(cfg.step_ceiling)) gd = 64'(cfg.step_ceiling);
               if (ga > 64'(ALPHA_MAX)) ga = 64'(ALPHA_MAX);
               if (ga < 64'(cfg.alpha_floor)) ga = 64'(cfg.alpha_floor);
               dt    = gd[31:0];
               alpha = ga[24:0];
            end
            if (pos_run != 32'hFFFF_FFFF) pos_run++;
         end else begin
            gd = (64'(dt) * 64'(cfg.step_shrink)) >> 24;
            if (gd < 64'(cfg.step_floor)) gd = 64'(cfg.step_floor);
            dt      = gd[31:0];
            pos_run = 0;
            alpha   = cfg.alpha_start;
         end
         zero_vel = reset_now;
         fnorm = 0; vnorm = 0; power = 0; count = 0;
         res.kind          = KIND_SUMMARY;
         res.word[191:160] = peak;
         res.word[223:192] = dt;
         res.word[248:224] = alpha;
         res.word[249]     = reset_now;
         pending.push_back(res);
      endfunction

      function void field(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
         end
      endfunction

      // accepted result transfer: compare with the oldest expectation
      function void check_result(logic kind, logic [255:0] w);
         relax_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, w);
            return;
         end
         e = pending.pop_front();
         field("result_kind", e.kind, kind);
         for (int j = 0; j < 5; j++)
            field($sformatf("new_vel[%0d]", j), e.word[32*j +: 32], w[32*j +: 32]);
         field("force_peak", e.word[191:160], w[191:160]);
         field("step_size", e.word[223:192], w[223:192]);
         field("alpha_now", e.word[248:224], w[248:224]);
         field("was_reset", e.word[249], w[249]);
         field("zero_fill", e.word[255:250], w[255:250]);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals and block
   // ------------------------------------------------------------------------
   logic         clock = 0, reset = 1;
   logic         req_tvalid = 0, req_tready, req_tlast = 0, req_tuser = 0;
   logic [319:0] req_tdata = '0;
   logic         rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [255:0] rsp_tdata;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0, csr_prdata;

   relax_scoreboard step_check = new();
   int          tx_idle_pct = 15, rx_idle_pct = 60;
   longint      cycles = 0;

   fire_relaxation_step u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) step_check.check_result(rsp_tuser, rsp_tdata);
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_penable = 0;
      csr_paddr = {idx, 2'b00}; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      step_check.set_reg(idx, val);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic send_item(logic action, logic last, logic [319:0] d);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1; req_tuser = action; req_tlast = last; req_tdata = d;
      do @(posedge clock); while (!req_tready);
      step_check.note_item(action, last, d);
   endtask

   // wait until every expected result is in, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (step_check.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(131071)) - 65536);
         2: case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'd1;
               default: return 32'd0;
            endcase
         default: return 32'($signed($urandom_range(2097151)) - 1048576);
      endcase
   endfunction

   // forces with velocities mostly aligned, so power is usually positive
   function automatic logic [319:0] rand_vectors();
      logic [319:0]       d;
      logic [31:0]        f;
      logic signed [31:0] fs;
      int                 mode;
      mode = $urandom_range(9);
      for (int j = 0; j < 5; j++) begin
         f = rand_word();
         d[32*j +: 32] = f;
         fs = $signed(f) >>> $urandom_range(8);
         if (mode < 7)
            d[160 + 32*j +: 32] = fs + 32'($urandom_range(15));
         else
            d[160 + 32*j +: 32] = rand_word();
      end
      return d;
   endfunction

   task automatic run_random(int n_items);
      int sent, n_red, n_mix;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 8) begin
            // noise: arbitrary kind and marker
            send_item($urandom_range(1), $urandom_range(1), rand_vectors());
            sent++;
         end else begin
            n_red = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            for (int i = 0; i < n_red; i++)
               send_item(ACT_REDUCE, i == n_red - 1, rand_vectors());
            n_mix = $urandom_range(7);
            for (int i = 0; i < n_mix; i++)
               send_item(ACT_MIX, $urandom_range(1), rand_vectors());
            sent += n_red + n_mix;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [319:0] d;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: mix before any reduce, extreme operands
      send_item(ACT_MIX, 1'b1, {160'h7FFF_FFFF_8000_0000_FFFF_FFFF_0000_0001_0000_0000,
                                160'h8000_0000_7FFF_FFFF_0000_0001_FFFF_FFFF_7FFF_FFFF});
      // zero force norm, zero power
      send_item(ACT_REDUCE, 1'b1, '0);
      send_item(ACT_MIX, 1'b0, {10{32'h7FFF_FFFF}});
      // saturating norms and power
      send_item(ACT_REDUCE, 1'b0, {10{32'h8000_0000}});
      send_item(ACT_REDUCE, 1'b0, {10{32'h8000_0000}});
      send_item(ACT_REDUCE, 1'b1, {10{32'h7FFF_FFFF}});
      send_item(ACT_MIX, 1'b1, {{5{32'h8000_0000}}, {5{32'h7FFF_FFFF}}});
      // huge quotient: tiny force, maximal velocity
      d = '0;
      d[31:0] = 32'd1;
      d[191:160] = 32'd1;
      for (int j = 1; j < 5; j++) d[160 + 32*j +: 32] = 32'h7FFF_FFFF;
      for (int k = 0; k < 8; k++) send_item(ACT_REDUCE, 1'b1, d);
      send_item(ACT_MIX, 1'b0, {{5{32'h0000_0001}}, {5{32'hFFFF_FFFF}}});
      send_item(ACT_MIX, 1'b1, {{5{32'h7FFF_FFFF}}, {5{32'h8000_0000}}});
      send_item(ACT_MIX, 1'b0, '1);
      // hold off until all is out
      drain();

      // growth allowed at once, no limits
      csr_write(REG_ALPHA_START, 32'd16777216);
      csr_write(REG_ALPHA_DECAY, 32'd16777216);
      csr_write(REG_ALPHA_FLOOR, 32'd0);
      csr_write(REG_STEP_GROW, 32'hFFFF_FFFF);
      csr_write(REG_STEP_SHRINK, 32'd16777216);
      csr_write(REG_STEP_CEIL, 32'hFFFF_FFFF);
      csr_write(REG_STEP_FLOOR, 32'd0);
      csr_write(REG_MIN_POS, 32'd0);
      run_random(480);
      drain();

      // alpha above one, zero multipliers, maximal floors
      tx_idle_pct = 60; rx_idle_pct = 15;
      csr_write(REG_ALPHA_START, 32'h01FF_FFFF);
      csr_write(REG_ALPHA_DECAY, 32'd0);
      csr_write(REG_ALPHA_FLOOR, 32'd16777216);
      csr_write(REG_STEP_GROW, 32'd0);
      csr_write(REG_STEP_SHRINK, 32'd0);
      csr_write(REG_STEP_CEIL, 32'd0);
      csr_write(REG_STEP_FLOOR, 32'hFFFF_FFFF);
      csr_write(REG_MIN_POS, 32'd65535);
      run_random(480);
      drain();

      // random settings, full rate on both sides
      tx_idle_pct = 0; rx_idle_pct = 0;
      csr_write(REG_ALPHA_START, $urandom_range(16777216));
      csr_write(REG_ALPHA_DECAY, $urandom_range(16777216));
      csr_write(REG_ALPHA_FLOOR, $urandom_range(8388608));
      csr_write(REG_STEP_GROW, $urandom_range(16777216, 33554432));
      csr_write(REG_STEP_SHRINK, $urandom_range(16777216));
      csr_write(REG_STEP_CEIL, $urandom());
      csr_write(REG_STEP_FLOOR, $urandom_range(1677722));
      csr_write(REG_MIN_POS, $urandom_range(3));
      run_random(480);
      drain();

      if (step_check.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
